>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Implication checks shared by the RTL; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define CMQD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define CMQD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CMQD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CMQD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/cmqd_pkg.sv
// ---------------------------------------------------------------------------
// cmqd_pkg
// Types, codes and ROM tables for the CUT-mode quadrant decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmqd_pkg;

   localparam int NumQuads = 4;
   localparam int NumSyms  = 77;
   localparam int SymIxW   = $clog2(NumSyms);

   localparam logic [2:0] QUAD_NONE = 3'd4;
   localparam logic [1:0] QUAD_TWO  = 2'd2;

   localparam logic [7:0] SEL_Q0     = 8'h5e;
   localparam logic [7:0] SEL_Q1     = 8'h7e;
   localparam logic [7:0] SEL_Q2     = 8'h5c;
   localparam logic [7:0] SEL_Q3     = 8'h7d;
   localparam logic [7:0] LOW_BYTE   = 8'h40;
   localparam logic [7:0] HIGH_BYTE  = 8'hf9;
   localparam logic [7:0] NULL_CODE  = 8'hc1;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SUB   = 8'h1a;

   typedef enum logic {
      CSR_ASCII_MODE = 1'b0,
      CSR_STRIP_CR   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       conv_error;
      logic       last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic ascii_mode;
      logic strip_cr;
   } cfg_type;

   localparam logic [7:0] QUAD_ROM [NumQuads][NumSyms] = '{
      '{8'h40,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hd1,8'hd2,
        8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'he2,8'he3,8'he4,8'he5,8'he6,
        8'he7,8'he8,8'he9,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
        8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'ha2,8'ha3,8'ha4,
        8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'hf0,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,
        8'hf7,8'hf8,8'hf9,8'h6c,8'h50,8'h6d,8'h4d,8'h5d,8'h4c,8'h4e,8'h6b,8'h60,
        8'h4b,8'h61,8'h7a,8'h6e,8'h6f},
      '{8'h20,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h4b,
        8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
        8'h58,8'h59,8'h5a,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,
        8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,
        8'h76,8'h77,8'h78,8'h79,8'h7a,8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,
        8'h37,8'h38,8'h39,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,
        8'h2e,8'h2f,8'h3a,8'h3b,8'h3f},
      '{8'h00,8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,
        8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,
        8'h17,8'h18,8'h19,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h3c,8'h3d,8'h3e,8'h00,8'hfa,8'hfb,8'hfc,
        8'hfd,8'hfe,8'hff,8'h7b,8'h7c,8'h7d,8'h7e,8'h7f,8'h1a,8'h1b,8'h1c,8'h1d,
        8'h1e,8'h1f,8'h00,8'h00,8'h00},
      '{8'h00,8'ha0,8'ha1,8'hea,8'heb,8'hec,8'hed,8'hee,8'hef,8'he0,8'he1,8'haa,
        8'hab,8'hac,8'had,8'hae,8'haf,8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
        8'hb7,8'hb8,8'hb9,8'h80,8'h00,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,8'hc0,
        8'h00,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h00,8'hda,8'hdb,8'hdc,
        8'hdd,8'hde,8'hdf,8'hd0,8'h00,8'h00,8'h21,8'h22,8'h23,8'h24,8'h5b,8'h5c,
        8'h00,8'h5e,8'h5f,8'h00,8'h9c,8'h9d,8'h9e,8'h9f,8'hba,8'hbb,8'hbc,8'hbd,
        8'hbe,8'hbf,8'h9a,8'h9b,8'h00}
   };

   // Position of b in the quadrant-0 alphabet; bit SymIxW flags a hit.
   function automatic logic [SymIxW:0] symbol_of(input logic [7:0] b);
      logic [SymIxW:0] res;
      res = '0;
      for (int i = NumSyms - 1; i >= 0; i--) begin
         if (QUAD_ROM[0][i] == b) begin
            res = {1'b1, SymIxW'(i)};
         end
      end
      return res;
   endfunction

endpackage

>>> rtl/cmqd_core.sv
// ---------------------------------------------------------------------------
// cmqd_core
// Quadrant and abort state plus the single-pass decode of one beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmqd_core
   import cmqd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [2:0]        quad_ff, quad_in;
   logic              abort_ff, abort_in;
   logic              sel_hit;
   logic [1:0]        sel_q;
   logic [SymIxW:0]   sym;
   logic [7:0]        rom_val;
   logic              fail;
   logic [7:0]        b;

   assign b = item.data_byte;

   always_comb begin
      sel_hit = 1'b1;
      sel_q   = 2'd0;
      case (b)
         SEL_Q0:  sel_q = 2'd0;
         SEL_Q1:  sel_q = 2'd1;
         SEL_Q2:  sel_q = 2'd2;
         SEL_Q3:  sel_q = 2'd3;
         default: sel_hit = 1'b0;
      endcase
   end

   assign sym     = symbol_of(b);
   assign rom_val = QUAD_ROM[quad_ff[1:0]][sym[SymIxW-1:0]];

   always_comb begin
      quad_in              = quad_ff;
      abort_in             = abort_ff;
      fail                 = 1'b0;
      result               = '0;
      result.last_of_frame = item.frame_end;
      if (item.kind) begin
         quad_in  = QUAD_NONE;
         abort_in = 1'b0;
      end else if (!abort_ff) begin
         if (quad_ff[2]) begin
            if (sel_hit) quad_in = {1'b0, sel_q};
            else         fail = 1'b1;
         end else if (b < LOW_BYTE || b > HIGH_BYTE) begin
            fail = 1'b1;
         end else if (!sym[SymIxW]) begin
            if (sel_hit) quad_in = {1'b0, sel_q};
            else         fail = 1'b1;
         end else if (quad_ff[1:0] != QUAD_TWO && b != NULL_CODE && rom_val == 8'h00) begin
            fail = 1'b1;
         end else if (!(cfg.ascii_mode && cfg.strip_cr &&
                        (rom_val == CHAR_CR || rom_val == CHAR_SUB))) begin
            result.out_valid = 1'b1;
            result.out_byte  = rom_val;
         end
         if (fail) begin
            abort_in          = 1'b1;
            quad_in           = QUAD_NONE;
            result.conv_error = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff  <= QUAD_NONE;
         abort_ff <= 1'b0;
      end else if (step) begin
         quad_ff  <= quad_in;
         abort_ff <= abort_in;
      end
   end

   `CMQD_ASSERT_IMP(a_quad_legal, clock, reset, quad_ff[2], quad_ff[1:0] == 2'd0)
   `CMQD_ASSERT_IMP(a_err_no_data, clock, reset, step, !(result.conv_error && result.out_valid))
   `CMQD_ASSERT_NXT(a_err_aborts, clock, reset, step && result.conv_error, abort_ff && quad_ff == QUAD_NONE)
   `CMQD_ASSERT_NXT(a_start_clears, clock, reset, step && item.kind, !abort_ff && quad_ff == QUAD_NONE)
   `CMQD_ASSERT_NXT(a_abort_holds, clock, reset, step && !item.kind && abort_ff, abort_ff && $stable(quad_ff))

endmodule

>>> rtl/cut_mode_quadrant_decoder_top.sv
// ---------------------------------------------------------------------------
// cut_mode_quadrant_decoder_top
// Decoder for the quadrant-shifted EBCDIC stream of a CUT-mode transfer.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  req_    | in        | req_valid / req_ready     | req_data  (req_type)
//  rsp_    | out       | rsp_valid / rsp_ready     | rsp_data  (rsp_type)
//  csr_    | in        | csr_valid / csr_ready     | csr_index, csr_wdata
//
//  Every accepted beat yields exactly one response beat: it is held in the input
//  register, then passes through the decode ROMs into the response register.
//  Sustained rate is one beat per cycle while the output is not stalled.
//  A stalled response back-pressures the input register only when both are full.
//  Reset clears the quadrant to none, the abort flag and both config bits.
//  The config port is always ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cut_mode_quadrant_decoder_top
   import cmqd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_index,
   input  logic    csr_wdata
);

   req_type item_ff;
   logic    item_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   cfg_type cfg_ff;
   logic    out_free;
   logic    step;

   // the response register takes a new beat when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || step;
   assign csr_ready = 1'b1;

   // input register: hold the beat until the decode stage advances
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   cmqd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (rsp_in)
   );

   // response register: advance on step, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ASCII_MODE: cfg_ff.ascii_mode <= csr_wdata;
            CSR_STRIP_CR:   cfg_ff.strip_cr   <= csr_wdata;
            default:        cfg_ff            <= cfg_ff;
         endcase
      end
   end

endmodule
